FILE: src/tlsp_pkg.sv
// tlsp_pkg: types and constants for the tunnel line scroll parameter block
// no dependencies; used by the interfaces, the divider and the top level
`timescale 1ns / 1ps

package tlsp_pkg;

    localparam int WIDTH_W    = 9;
    localparam int FRAME_W    = 16;
    localparam int COLOR_W    = 12;
    localparam int BANK_W     = 3;
    localparam int OFFSET_W   = 13;
    localparam int FINE_W     = 8;
    localparam int PROD_W     = 25;
    localparam int PHASE_W    = 23;
    localparam int MAG_W      = 21;
    localparam int DIV_STEPS  = 3;
    localparam int DIV_STAGES = MAG_W / DIV_STEPS;
    localparam int HALF_SPAN  = 1280;

    typedef logic        [WIDTH_W-1:0]  t_width;
    typedef logic signed [FRAME_W-1:0]  t_frame;
    typedef logic        [COLOR_W-1:0]  t_color;
    typedef logic        [BANK_W-1:0]   t_bank;
    typedef logic        [OFFSET_W-1:0] t_offset;
    typedef logic        [FINE_W-1:0]   t_fine;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [PHASE_W-1:0]  t_phase;
    typedef logic        [MAG_W-1:0]    t_mag;

    typedef struct packed {
        t_mag    mag;
        t_width  rem;
        logic    qlsb;
        logic    neg;
        t_width  width;
        t_offset off;
        t_color  ca;
        t_color  cb;
    } t_div_item;

endpackage

FILE: src/tlsp_if.sv
// tlsp_if: valid/ready channels for line items and scroll result items
// depends on tlsp_pkg for field types
`timescale 1ns / 1ps

interface tlsp_in_if;
    logic              valid;
    logic              ready;
    tlsp_pkg::t_width  stripe_width;
    tlsp_pkg::t_frame  frame_number;
    tlsp_pkg::t_color  color_a;
    tlsp_pkg::t_color  color_b;

    modport source (output valid, output stripe_width, output frame_number,
                    output color_a, output color_b, input ready);
    modport sink   (input valid, input stripe_width, input frame_number,
                    input color_a, input color_b, output ready);
endinterface

interface tlsp_out_if;
    logic              valid;
    logic              ready;
    tlsp_pkg::t_bank   pattern_bank;
    tlsp_pkg::t_offset row_byte_offset;
    tlsp_pkg::t_fine   fine_shift;
    tlsp_pkg::t_color  color_first;
    tlsp_pkg::t_color  color_second;

    modport source (output valid, output pattern_bank, output row_byte_offset,
                    output fine_shift, output color_first, output color_second,
                    input ready);
    modport sink   (input valid, input pattern_bank, input row_byte_offset,
                    input fine_shift, input color_first, input color_second,
                    output ready);
endinterface

FILE: src/tlsp_divider.sv
// tlsp_divider: pipelined restoring divider, magnitude by stripe width
// depends on tlsp_pkg; each stage retires DIV_STEPS quotient bits
`timescale 1ns / 1ps

module tlsp_divider (
    input  logic                                i_clk,
    input  logic [tlsp_pkg::DIV_STAGES-1:0]     i_load,
    input  tlsp_pkg::t_div_item                 i_item,
    output tlsp_pkg::t_div_item                 o_item
);

    tlsp_pkg::t_div_item r_stage [tlsp_pkg::DIV_STAGES];
    tlsp_pkg::t_div_item n_stage [tlsp_pkg::DIV_STAGES];
    tlsp_pkg::t_div_item w_src   [tlsp_pkg::DIV_STAGES];

    assign w_src[0] = i_item;

    genvar j;
    generate
        for (j = 0; j < tlsp_pkg::DIV_STAGES; j++) begin : g_stage
            if (j > 0) begin : g_link
                assign w_src[j] = r_stage[j-1];
            end

            always_comb begin
                tlsp_pkg::t_div_item      cur;
                logic [tlsp_pkg::WIDTH_W:0] part;
                cur = w_src[j];
                for (int s = 0; s < tlsp_pkg::DIV_STEPS; s++) begin
                    part    = {cur.rem, cur.mag[tlsp_pkg::MAG_W-1]};
                    cur.mag = cur.mag << 1;
                    if (part >= {1'b0, cur.width}) begin
                        part     = part - {1'b0, cur.width};
                        cur.qlsb = 1'b1;
                    end else begin
                        cur.qlsb = 1'b0;
                    end
                    cur.rem = part[tlsp_pkg::WIDTH_W-1:0];
                end
                n_stage[j] = cur;
            end

            always_ff @(posedge i_clk) begin
                if (i_load[j]) begin
                    r_stage[j] <= n_stage[j];
                end
            end
        end
    endgenerate

    assign o_item = r_stage[tlsp_pkg::DIV_STAGES-1];

endmodule

FILE: src/tunnel_line_scroll_params.sv
// tunnel_line_scroll_params: per-line pattern bank, row offset, fine scroll and colours
// depends on tlsp_pkg, tlsp_if and tlsp_divider
//
//   channel  dir  handshake      payload
//   i_item   in   valid/ready    stripe_width, frame_number, color_a, color_b
//   o_item   out  valid/ready    pattern_bank, row_byte_offset, fine_shift,
//                                color_first, color_second
//
// one item per cycle sustained while the output is ready; stages in order: multiply,
// phase and magnitude, seven divider stages of three restoring steps, sign fix-up, output
// every stage has its own valid bit and a stall holds only the full stages
// behind the output, so bubbles close up and input keeps flowing
// synchronous active-low reset clears the valid bits only
`timescale 1ns / 1ps

module tunnel_line_scroll_params #(
    parameter int MIN_WIDTH = 168,
    parameter int ROW_BYTES = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlsp_in_if.sink     i_item,
    tlsp_out_if.source  o_item
);

    localparam int DIV_FIRST = 2;
    localparam int FIX       = DIV_FIRST + tlsp_pkg::DIV_STAGES;
    localparam int OUT       = FIX + 1;
    localparam int NSTG      = OUT + 1;

    localparam tlsp_pkg::t_offset MIN_W = tlsp_pkg::t_offset'(MIN_WIDTH);
    localparam tlsp_pkg::t_offset ROW_B = tlsp_pkg::t_offset'(ROW_BYTES);

    logic [NSTG:0]   w_ready;
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] n_vld;

    // stage 0
    tlsp_pkg::t_prod   r_prod;
    tlsp_pkg::t_width  r_w0;
    tlsp_pkg::t_color  r_ca0;
    tlsp_pkg::t_color  r_cb0;
    tlsp_pkg::t_prod   n_prod;

    // stage 1
    tlsp_pkg::t_div_item r_div_in;
    tlsp_pkg::t_div_item n_div_in;
    tlsp_pkg::t_div_item w_div_out;

    // fix-up stage
    tlsp_pkg::t_width  r_rem_f;
    logic              r_odd_f;
    tlsp_pkg::t_offset r_off_f;
    tlsp_pkg::t_color  r_ca_f;
    tlsp_pkg::t_color  r_cb_f;
    tlsp_pkg::t_width  n_rem_f;
    logic              n_odd_f;

    // output stage
    tlsp_pkg::t_bank   r_bank;
    tlsp_pkg::t_offset r_offset;
    tlsp_pkg::t_fine   r_fine;
    tlsp_pkg::t_color  r_first;
    tlsp_pkg::t_color  r_second;

    // ready ripples back from the output, a stage moves when empty or draining
    always_comb begin
        w_ready[NSTG] = o_item.ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            w_ready[k] = !r_vld[k] || w_ready[k+1];
        end
    end

    assign n_vld = {r_vld[NSTG-2:0], i_item.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NSTG; k++) begin
                if (w_ready[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    assign i_item.ready = w_ready[0];

    // stage 0: width times frame
    assign n_prod = tlsp_pkg::t_prod'($signed({1'b0, i_item.stripe_width}))
                  * tlsp_pkg::t_prod'(i_item.frame_number);

    always_ff @(posedge i_clk) begin
        if (w_ready[0]) begin
            r_prod <= n_prod;
            r_w0   <= i_item.stripe_width;
            r_ca0  <= i_item.color_a;
            r_cb0  <= i_item.color_b;
        end
    end

    // stage 1: phase, sign and magnitude, row base
    always_comb begin
        tlsp_pkg::t_phase phase;
        phase = tlsp_pkg::t_phase'(r_prod >>> 3)
              - tlsp_pkg::t_phase'(tlsp_pkg::HALF_SPAN);
        n_div_in.neg   = phase[tlsp_pkg::PHASE_W-1];
        n_div_in.mag   = phase[tlsp_pkg::PHASE_W-1] ? tlsp_pkg::t_mag'(-phase)
                                                    : tlsp_pkg::t_mag'(phase);
        n_div_in.rem   = '0;
        n_div_in.qlsb  = 1'b0;
        n_div_in.width = r_w0;
        n_div_in.off   = (tlsp_pkg::t_offset'(r_w0) - MIN_W) * ROW_B;
        n_div_in.ca    = r_ca0;
        n_div_in.cb    = r_cb0;
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[1]) begin
            r_div_in <= n_div_in;
        end
    end

    tlsp_divider u_divider (
        .i_clk  (i_clk),
        .i_load (w_ready[DIV_FIRST +: tlsp_pkg::DIV_STAGES]),
        .i_item (r_div_in),
        .o_item (w_div_out)
    );

    // fix-up: non-negative remainder and floor quotient parity
    always_comb begin
        logic adjust;
        adjust  = w_div_out.neg && (w_div_out.rem != '0);
        n_rem_f = adjust ? (w_div_out.width - w_div_out.rem) : w_div_out.rem;
        n_odd_f = w_div_out.qlsb ^ adjust;
        if (w_div_out.width == '0) begin
            n_rem_f = '0;
            n_odd_f = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready[FIX]) begin
            r_rem_f <= n_rem_f;
            r_odd_f <= n_odd_f;
            r_off_f <= w_div_out.off;
            r_ca_f  <= w_div_out.ca;
            r_cb_f  <= w_div_out.cb;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_ready[OUT]) begin
            r_bank   <= r_rem_f[2:0];
            r_offset <= r_off_f + tlsp_pkg::t_offset'({r_rem_f[8:7], 1'b0});
            r_fine   <= {~r_rem_f[6:3], ~r_rem_f[6:3]};
            r_first  <= r_odd_f ? r_cb_f : r_ca_f;
            r_second <= r_odd_f ? r_ca_f : r_cb_f;
        end
    end

    assign o_item.valid           = r_vld[OUT];
    assign o_item.pattern_bank    = r_bank;
    assign o_item.row_byte_offset = r_offset;
    assign o_item.fine_shift      = r_fine;
    assign o_item.color_first     = r_first;
    assign o_item.color_second    = r_second;

    // input held off only when every stage is full
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_ready[0] |-> (&r_vld))
        else $error("input stalled with an empty stage");

    // divider remainder below the width
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[FIX-1] && (w_div_out.width != '0)) |-> (w_div_out.rem < w_div_out.width))
        else $error("divider remainder not below width");

    // items in flight change only by accepts in and out
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |->
            ($countones(r_vld) == $countones($past(r_vld))
                + $past(i_item.valid && i_item.ready)
                - $past(o_item.valid && o_item.ready)))
        else $error("item lost or repeated in pipeline");

endmodule
